// ----- rtl/ps2_mouse_packet_tracker_core_macros.svh -----
// Assertion macros used by the mouse packet tracker core.
`ifndef PS2_MOUSE_PACKET_TRACKER_CORE_MACROS_SVH
`define PS2_MOUSE_PACKET_TRACKER_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PS2MPT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ps2mpt: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define PS2MPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ps2mpt: next-cycle check failed");

`endif

// ----- rtl/ps2mpt_pkg.sv -----
// Types and constants for the PS/2 mouse packet tracker.
`default_nettype none

package ps2mpt_pkg;

  localparam int SIZE_BITS    = 13;
  localparam int CFG_IDX_BITS = 1;
  localparam int DELTA_BITS   = 9;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_HEIGHT = 1'd1;

  localparam logic [SIZE_BITS-1:0] SCREEN_WIDTH_RESET  = 13'd1024;
  localparam logic [SIZE_BITS-1:0] SCREEN_HEIGHT_RESET = 13'd768;

  // Command codes.
  localparam logic CMD_BYTE     = 1'b0;
  localparam logic CMD_RECENTRE = 1'b1;

  // Bit positions in the controller status and packet header.
  localparam int STATUS_OUT_FULL = 0;
  localparam int STATUS_AUX      = 5;
  localparam int HDR_SYNC        = 3;
  localparam int HDR_X_SIGN      = 4;
  localparam int HDR_Y_SIGN      = 5;
  localparam int BUTTON_LEFT     = 0;

  typedef logic [SIZE_BITS-1:0] size_t;
  typedef logic [11:0]          coord_t;
  typedef logic [2:0]           buttons_t;
  typedef logic [7:0]           byte_t;

  typedef enum logic [1:0] {
    PHASE_HEADER = 2'd0,
    PHASE_X      = 2'd1,
    PHASE_Y      = 2'd2
  } phase_t;

  typedef struct packed {
    logic  command;
    byte_t status_byte;
    byte_t data_byte;
  } in_item_t;

  typedef struct packed {
    logic     accepted;
    logic     packet_done;
    coord_t   cursor_x;
    coord_t   cursor_y;
    buttons_t button_bits;
    logic     left_pressed;
    logic     left_released;
  } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/ps2mpt_axis.sv -----
// One cursor axis: applies a signed delta, clamps to the screen, or recentres.
`default_nettype none

module ps2mpt_axis #(
  parameter int COORD_BITS = 12
) (
  input  wire ps2mpt_pkg::size_t                        size,
  input  wire logic [COORD_BITS-1:0]                    pos,
  input  wire logic [ps2mpt_pkg::DELTA_BITS-1:0]        delta,
  input  wire logic                                     subtract,
  input  wire logic                                     update,
  input  wire logic                                     recentre,
  output logic      [COORD_BITS-1:0]                    pos_next
);

  localparam int WIDE = (COORD_BITS > ps2mpt_pkg::SIZE_BITS) ? COORD_BITS
                                                             : ps2mpt_pkg::SIZE_BITS;
  localparam int SUM_BITS = COORD_BITS + 2;

  logic [WIDE-1:0]             cap_w;
  logic [WIDE-1:0]             lim_raw_w;
  logic [WIDE-1:0]             lim_w;
  logic [WIDE-1:0]             half_w;
  logic [WIDE-1:0]             centre_w;
  logic [COORD_BITS-1:0]       lim;
  logic signed [SUM_BITS-1:0]  pos_s;
  logic signed [SUM_BITS-1:0]  delta_s;
  logic signed [SUM_BITS-1:0]  sum;
  logic signed [SUM_BITS-1:0]  lim_s;
  logic [COORD_BITS-1:0]       clamped;

  always_comb begin
    cap_w     = WIDE'({COORD_BITS{1'b1}});
    // A zero size behaves like a size of one.
    lim_raw_w = (size == '0) ? '0 : WIDE'(size - ps2mpt_pkg::size_t'(1));
    lim_w     = (lim_raw_w > cap_w) ? cap_w : lim_raw_w;
    half_w    = WIDE'(size >> 1);
    centre_w  = (half_w > cap_w) ? cap_w : half_w;
    lim       = lim_w[COORD_BITS-1:0];

    pos_s   = $signed({2'b00, pos});
    delta_s = $signed({{(SUM_BITS - ps2mpt_pkg::DELTA_BITS){delta[ps2mpt_pkg::DELTA_BITS-1]}},
                       delta});
    sum     = subtract ? (pos_s - delta_s) : (pos_s + delta_s);
    lim_s   = $signed({2'b00, lim});

    if (sum < 0) begin
      clamped = '0;
    end else if (sum > lim_s) begin
      clamped = lim;
    end else begin
      clamped = sum[COORD_BITS-1:0];
    end

    if (recentre) begin
      pos_next = centre_w[COORD_BITS-1:0];
    end else if (update) begin
      pos_next = clamped;
    end else begin
      pos_next = pos;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ps2_mouse_packet_tracker_core.sv -----
// Top level of the PS/2 mouse packet tracker: packet reassembly and cursor tracking.
`default_nettype none

// Takes controller status/data byte pairs (or a recentre command) and returns one
// result item for every input item: whether the byte was mouse data, whether it
// finished a three-byte packet, the clamped cursor position, the held buttons and
// the left-button press and release edges of the last packet. A byte counts only
// when the status shows output full and aux data; a packet header must have bit 3
// set or it is dropped. Each item is updated by the adder and clamp logic in front
// of the result register, so a new item is accepted in every cycle as long as the
// result register is empty or being emptied. Screen width and height must be written
// through the configuration port while the block is idle, which the block does not
// enforce; they take effect at the next packet or recentre. COORD_BITS sets the
// width of the internal position registers; reported coordinates are its low 12 bits.

`include "ps2_mouse_packet_tracker_core_macros.svh"

module ps2_mouse_packet_tracker_core #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    in_valid,
  output logic                                         in_stall,
  input  wire ps2mpt_pkg::in_item_t                    in_data,
  output logic                                         out_valid,
  input  wire logic                                    out_stall,
  output ps2mpt_pkg::out_item_t                        out_data,
  input  wire logic                                    cfg_wr_en,
  input  wire logic [ps2mpt_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  wire ps2mpt_pkg::size_t                       cfg_data
);

  localparam logic [COORD_BITS-1:0] POS_X_RESET = COORD_BITS'(512);
  localparam logic [COORD_BITS-1:0] POS_Y_RESET = COORD_BITS'(384);

  // Configuration registers.
  ps2mpt_pkg::size_t screen_width;
  ps2mpt_pkg::size_t screen_height;

  // Tracker state.
  ps2mpt_pkg::phase_t    phase, phase_next;
  ps2mpt_pkg::byte_t     header_byte, header_byte_next;
  ps2mpt_pkg::byte_t     x_delta_byte, x_delta_byte_next;
  logic [COORD_BITS-1:0] pos_x, pos_x_next;
  logic [COORD_BITS-1:0] pos_y, pos_y_next;
  ps2mpt_pkg::buttons_t  buttons_now, buttons_now_next;
  ps2mpt_pkg::buttons_t  buttons_before, buttons_before_next;

  ps2mpt_pkg::out_item_t result;

  logic take;
  logic is_mouse;
  logic recentre;
  logic accepted;
  logic done;
  logic [ps2mpt_pkg::DELTA_BITS-1:0] dx;
  logic [ps2mpt_pkg::DELTA_BITS-1:0] dy;

  // The result register holds one item; the input side waits only while that
  // item is still there and the consumer is stalling.
  assign in_stall = out_valid && out_stall;
  assign take     = in_valid && !in_stall;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= ps2mpt_pkg::SCREEN_WIDTH_RESET;
      screen_height <= ps2mpt_pkg::SCREEN_HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ps2mpt_pkg::CFG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        ps2mpt_pkg::CFG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Packet reassembly. The next-state logic is only committed when an item is
  // taken, so it can be computed unconditionally here.
  always_comb begin
    is_mouse = in_data.status_byte[ps2mpt_pkg::STATUS_OUT_FULL] &&
               in_data.status_byte[ps2mpt_pkg::STATUS_AUX];
    recentre = (in_data.command == ps2mpt_pkg::CMD_RECENTRE);

    phase_next          = phase;
    header_byte_next    = header_byte;
    x_delta_byte_next   = x_delta_byte;
    buttons_now_next    = buttons_now;
    buttons_before_next = buttons_before;
    accepted            = 1'b0;
    done                = 1'b0;

    if (recentre) begin
      accepted          = 1'b1;
      phase_next        = ps2mpt_pkg::PHASE_HEADER;
      header_byte_next  = '0;
      x_delta_byte_next = '0;
    end else if (is_mouse) begin
      accepted = 1'b1;
      case (phase)
        ps2mpt_pkg::PHASE_X: begin
          x_delta_byte_next = in_data.data_byte;
          phase_next        = ps2mpt_pkg::PHASE_Y;
        end
        ps2mpt_pkg::PHASE_Y: begin
          buttons_before_next = buttons_now;
          buttons_now_next    = header_byte[2:0];
          phase_next          = ps2mpt_pkg::PHASE_HEADER;
          done                = 1'b1;
        end
        default: begin
          // Header phase, and the unused phase code, wait for a synced header.
          if (in_data.data_byte[ps2mpt_pkg::HDR_SYNC]) begin
            header_byte_next = in_data.data_byte;
            phase_next       = ps2mpt_pkg::PHASE_X;
          end else begin
            phase_next = ps2mpt_pkg::PHASE_HEADER;
          end
        end
      endcase
    end
  end

  // The header carries the ninth (sign) bits of both movement bytes.
  assign dx = {header_byte[ps2mpt_pkg::HDR_X_SIGN], x_delta_byte};
  assign dy = {header_byte[ps2mpt_pkg::HDR_Y_SIGN], in_data.data_byte};

  // X grows with the delta; Y shrinks with it since screen Y points down.
  ps2mpt_axis #(
    .COORD_BITS (COORD_BITS)
  ) u_axis_x (
    .size     (screen_width),
    .pos      (pos_x),
    .delta    (dx),
    .subtract (1'b0),
    .update   (done),
    .recentre (recentre),
    .pos_next (pos_x_next)
  );

  ps2mpt_axis #(
    .COORD_BITS (COORD_BITS)
  ) u_axis_y (
    .size     (screen_height),
    .pos      (pos_y),
    .delta    (dy),
    .subtract (1'b1),
    .update   (done),
    .recentre (recentre),
    .pos_next (pos_y_next)
  );

  // The result reflects the state after this item. Edges compare the two most
  // recent packets' left button and so hold between packets.
  always_comb begin
    result.accepted      = accepted;
    result.packet_done   = done;
    result.cursor_x      = ps2mpt_pkg::coord_t'(pos_x_next);
    result.cursor_y      = ps2mpt_pkg::coord_t'(pos_y_next);
    result.button_bits   = buttons_now_next;
    result.left_pressed  = !buttons_before_next[ps2mpt_pkg::BUTTON_LEFT] &&
                            buttons_now_next[ps2mpt_pkg::BUTTON_LEFT];
    result.left_released =  buttons_before_next[ps2mpt_pkg::BUTTON_LEFT] &&
                           !buttons_now_next[ps2mpt_pkg::BUTTON_LEFT];
  end

  // Tracker state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= ps2mpt_pkg::PHASE_HEADER;
      header_byte    <= '0;
      x_delta_byte   <= '0;
      pos_x          <= POS_X_RESET;
      pos_y          <= POS_Y_RESET;
      buttons_now    <= '0;
      buttons_before <= '0;
    end else if (take) begin
      phase          <= phase_next;
      header_byte    <= header_byte_next;
      x_delta_byte   <= x_delta_byte_next;
      pos_x          <= pos_x_next;
      pos_y          <= pos_y_next;
      buttons_now    <= buttons_now_next;
      buttons_before <= buttons_before_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= result;
    end
  end

  // A finished packet is always a counted byte.
  `PS2MPT_ASSERT_NOW(a_done_is_accepted, clk, rst, out_valid && out_data.packet_done, out_data.accepted)

  // One packet cannot both press and release the left button.
  `PS2MPT_ASSERT_NOW(a_edges_exclusive, clk, rst, out_valid, !(out_data.left_pressed && out_data.left_released))

  // Every taken item shows up in the result register on the next cycle.
  `PS2MPT_ASSERT_NEXT(a_take_gives_result, clk, rst, take, out_valid)

  // A recentre, or a completed packet, leaves reassembly waiting for a header.
  `PS2MPT_ASSERT_NEXT(a_restart_after_packet, clk, rst, take && (recentre || done), phase == ps2mpt_pkg::PHASE_HEADER)

endmodule

`default_nettype wire
